// ===== rtl/core/ccms_pkg.sv =====
// ccms_pkg: shared types and constants for the CCM* frame engine.
// Holds the AES S-box, GF(2^8) doubling, codes and the AES unit interface.
// No dependencies.
`default_nettype none
package ccms_pkg;

    localparam int LENGTH_FIELD_BYTES = 2;
    localparam logic [7:0] FLAG_L = 8'((LENGTH_FIELD_BYTES - 1) & 8'h07);
    localparam logic [7:0] FLAG_ADATA = 8'h40;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_AAD   = 2'd1;
    localparam logic [1:0] OP_PAY   = 2'd2;
    localparam logic [1:0] OP_TAG   = 2'd3;

    localparam logic [1:0] KIND_PAY  = 2'd0;
    localparam logic [1:0] KIND_TAG  = 2'd1;
    localparam logic [1:0] KIND_VERD = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_LEN  = 2'd1;
    localparam logic [1:0] ST_MISMATCH = 2'd2;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_AAD  = 2'd1;
    localparam logic [1:0] PH_PAY  = 2'd2;
    localparam logic [1:0] PH_TAG  = 2'd3;

    localparam logic [1:0] CFG_KEY_UP  = 2'd0;
    localparam logic [1:0] CFG_KEY_LO  = 2'd1;
    localparam logic [1:0] CFG_TAG_LEN = 2'd2;
    localparam logic [1:0] CFG_DIR     = 2'd3;

    typedef struct packed {
        logic         start;
        logic [127:0] block;
    } t_aes_req;

    typedef struct packed {
        logic         done;
        logic [127:0] result;
    } t_aes_rsp;

    localparam logic [7:0] SBOX [0:255] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/ccms_aes.sv =====
// ccms_aes: iterative AES-128 encrypt, one round per cycle, key expanded on the fly.
// Uses ccms_pkg (S-box, xtime, request/response structs).
`default_nettype none
module ccms_aes
    import ccms_pkg::*;
(
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire t_aes_req       i_req,
    input  wire logic [127:0]   i_key,
    output t_aes_rsp            o_rsp
);

    logic [127:0] r_s;
    logic [127:0] r_rk;
    logic [3:0]   r_rnd;
    logic [7:0]   r_rcon;
    logic         r_busy;
    logic         r_done;

    logic [7:0]   sub [16];
    logic [7:0]   sh  [16];
    logic [7:0]   mx  [16];
    logic [7:0]   rk  [16];
    logic [7:0]   nrk [16];
    logic [127:0] n_s;
    logic [127:0] n_rk;

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            sub[i] = SBOX[r_s[127 - 8*i -: 8]];
            rk[i]  = r_rk[127 - 8*i -: 8];
        end
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                sh[i + 4*c] = sub[i + 4*((c + i) % 4)];
            end
        end
        for (int c = 0; c < 4; c++) begin
            if (r_rnd != 4'd10) begin
                mx[4*c]   = sh[4*c] ^ (sh[4*c] ^ sh[4*c+1] ^ sh[4*c+2] ^ sh[4*c+3])
                          ^ xtime(sh[4*c] ^ sh[4*c+1]);
                mx[4*c+1] = sh[4*c+1] ^ (sh[4*c] ^ sh[4*c+1] ^ sh[4*c+2] ^ sh[4*c+3])
                          ^ xtime(sh[4*c+1] ^ sh[4*c+2]);
                mx[4*c+2] = sh[4*c+2] ^ (sh[4*c] ^ sh[4*c+1] ^ sh[4*c+2] ^ sh[4*c+3])
                          ^ xtime(sh[4*c+2] ^ sh[4*c+3]);
                mx[4*c+3] = sh[4*c+3] ^ (sh[4*c] ^ sh[4*c+1] ^ sh[4*c+2] ^ sh[4*c+3])
                          ^ xtime(sh[4*c+3] ^ sh[4*c]);
            end else begin
                mx[4*c]   = sh[4*c];
                mx[4*c+1] = sh[4*c+1];
                mx[4*c+2] = sh[4*c+2];
                mx[4*c+3] = sh[4*c+3];
            end
        end
        nrk[0] = rk[0] ^ SBOX[rk[13]] ^ r_rcon;
        nrk[1] = rk[1] ^ SBOX[rk[14]];
        nrk[2] = rk[2] ^ SBOX[rk[15]];
        nrk[3] = rk[3] ^ SBOX[rk[12]];
        for (int i = 4; i < 16; i++) begin
            nrk[i] = rk[i] ^ nrk[i - 4];
        end
        for (int i = 0; i < 16; i++) begin
            n_rk[127 - 8*i -: 8] = nrk[i];
            n_s[127 - 8*i -: 8]  = mx[i] ^ nrk[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_rnd  <= 4'd0;
        end else begin
            r_done <= r_busy && (r_rnd == 4'd10);
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_rnd  <= 4'd1;
            end else if (r_busy) begin
                r_rnd <= r_rnd + 4'd1;
                if (r_rnd == 4'd10) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_s    <= i_req.block ^ i_key;
            r_rk   <= i_key;
            r_rcon <= 8'h01;
        end else if (r_busy) begin
            r_s    <= n_s;
            r_rk   <= n_rk;
            r_rcon <= xtime(r_rcon);
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_s;

    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rnd >= 4'd1 && r_rnd <= 4'd10))
        else $error("aes round counter out of range");
    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy) && ($past(r_rnd) == 4'd10))
        else $error("aes done without final round");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("aes done while still busy");

endmodule
`default_nettype wire

// ===== rtl/core/ccm_star_aes_frame_engine.sv =====
// ccm_star_aes_frame_engine: CCM* (L=2, 13-byte nonce) frame engine on AES-128.
// Uses ccms_pkg and ccms_aes (one shared iterative AES unit).
//
// Channels: input word (opcode, nonce, lengths, data byte) on i_in_valid /
// o_in_ready; result word (kind, data, status, last) on o_out_valid /
// i_out_ready; register writes on i_cfg_valid / o_cfg_ready (always ready).
// Every AES pass runs on the shared round unit. A start word runs the B0
// pass. An AAD word is stored in the pending block and runs an absorb pass
// when it closes a 16-byte block or ends the AAD. A payload word runs a
// counter pass at each block start and an absorb pass when it closes a
// block or ends the payload. The word that ends the data adds a final pass
// (counter block 0); in encrypt mode with a tag it then emits tag bytes one
// per cycle when the receiver is ready. The last tag word is compared (verdict).
// The block takes one word at a time; o_in_ready is low while a word is
// being worked on. Results sit in a single output register; while the
// receiver stalls, the sequencer waits with the next result and takes no
// input. Reset clears the registers to key 0, tag length 8, encrypt, and
// leaves the frame idle.
`default_nettype none
module ccm_star_aes_frame_engine
    import ccms_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 127
)(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_ready,
    input  wire logic [1:0]   i_opcode,
    input  wire logic [39:0]  i_nonce_head,
    input  wire logic [63:0]  i_nonce_tail,
    input  wire logic [6:0]   i_aad_length,
    input  wire logic [6:0]   i_payload_length,
    input  wire logic [7:0]   i_data_in,
    output logic              o_out_valid,
    input  wire logic         i_out_ready,
    output logic [1:0]        o_kind,
    output logic [7:0]        o_data_out,
    output logic [1:0]        o_status,
    output logic              o_last,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [1:0]   i_cfg_index,
    input  wire logic [63:0]  i_cfg_data
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_B0   = 4'd1;
    localparam logic [3:0] S_POST = 4'd2;
    localparam logic [3:0] S_ABS  = 4'd3;
    localparam logic [3:0] S_CTR  = 4'd4;
    localparam logic [3:0] S_EMIT = 4'd5;
    localparam logic [3:0] S_S0   = 4'd6;
    localparam logic [3:0] S_TOUT = 4'd7;
    localparam logic [3:0] S_VERD = 4'd8;
    localparam logic [3:0] S_CMP  = 4'd9;

    localparam logic [7:0] MAX_LEN = 8'(MAX_FRAME_BYTES);

    logic [63:0]  r_key_up, r_key_lo;
    logic [4:0]   r_tag_len_cfg;
    logic         r_dir_cfg;

    logic [3:0]   r_state;
    logic [1:0]   r_phase;
    logic [4:0]   r_m;
    logic         r_dir;
    logic         r_has_pay;
    logic [127:0] r_mac, r_ks, r_pend, r_rtag;
    logic [103:0] r_nonce;
    logic [15:0]  r_ctr;
    logic [6:0]   r_aad_left, r_pay_left;
    logic [4:0]   r_bib;
    logic [7:0]   r_din;
    logic [1:0]   r_vstat;

    logic         r_ov;
    logic [1:0]   r_kind, r_stat;
    logic [7:0]   r_dout;
    logic         r_last;

    t_aes_req     aes_req;
    t_aes_rsp     aes_rsp;

    logic         in_acc;
    logic         slot_free;
    logic         emit;
    logic [3:0]   bidx;
    logic [7:0]   ks_byte, o_byte;
    logic         m_ok, len_ok;
    logic [7:0]   len_sum;
    logic [2:0]   m_field;
    logic [7:0]   flags;
    logic         data_done, need_abs;
    logic [127:0] tag_masked;

    ccms_aes u_aes (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (aes_req),
        .i_key   ({r_key_up, r_key_lo}),
        .o_rsp   (aes_rsp)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;
    assign slot_free   = !r_ov || i_out_ready;
    assign emit        = slot_free
                      && ((r_state == S_EMIT) || (r_state == S_TOUT) || (r_state == S_VERD));
    assign bidx        = r_bib[3:0];
    assign ks_byte     = r_ks[8*(4'd15 - bidx) +: 8];
    assign o_byte      = r_din ^ ks_byte;

    assign m_ok    = (r_tag_len_cfg == 5'd0) || (r_tag_len_cfg == 5'd4)
                  || (r_tag_len_cfg == 5'd8) || (r_tag_len_cfg == 5'd16);
    assign len_sum = {1'b0, i_aad_length} + {1'b0, i_payload_length};
    assign len_ok  = (len_sum <= MAX_LEN);
    // M field is (M-2)/2, i.e. M/2 - 1
    assign m_field = 3'(r_tag_len_cfg[4:1] - 4'd1);
    assign flags   = FLAG_L
                   | ((r_tag_len_cfg != 5'd0) ? {2'b00, m_field, 3'b000} : 8'h00)
                   | ((i_aad_length != 7'd0) ? FLAG_ADATA : 8'h00);

    assign data_done = ((r_phase == PH_AAD) && (r_aad_left == 7'd0))
                    || ((r_phase == PH_PAY) && (r_pay_left == 7'd0));
    assign need_abs  = (r_bib == 5'd16) || (data_done && (r_bib != 5'd0));

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            tag_masked[127 - 8*i -: 8] = (5'(i) < r_m)
                ? (r_mac[127 - 8*i -: 8] ^ aes_rsp.result[127 - 8*i -: 8]) : 8'h00;
        end
    end

    always_comb begin
        aes_req.start = 1'b0;
        aes_req.block = {r_mac ^ r_pend};
        case (r_state)
            S_IDLE: begin
                if (in_acc && (i_opcode == OP_START) && m_ok && len_ok) begin
                    aes_req.start = 1'b1;
                    aes_req.block = {flags, i_nonce_head, i_nonce_tail, 8'h00,
                                     1'b0, i_payload_length};
                end else if (in_acc && (i_opcode == OP_PAY) && (r_phase == PH_PAY)
                             && (r_bib == 5'd0)) begin
                    aes_req.start = 1'b1;
                    aes_req.block = {FLAG_L, r_nonce, r_ctr};
                end
            end
            S_POST: begin
                if (need_abs) begin
                    aes_req.start = 1'b1;
                end else if (data_done && !((r_phase == PH_AAD) && (r_pay_left != 7'd0))) begin
                    aes_req.start = 1'b1;
                    aes_req.block = {FLAG_L, r_nonce, 16'd0};
                end
            end
            default: begin
                aes_req.start = 1'b0;
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_up      <= 64'd0;
            r_key_lo      <= 64'd0;
            r_tag_len_cfg <= 5'd8;
            r_dir_cfg     <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_KEY_UP:  r_key_up      <= i_cfg_data;
                CFG_KEY_LO:  r_key_lo      <= i_cfg_data;
                CFG_TAG_LEN: r_tag_len_cfg <= i_cfg_data[4:0];
                CFG_DIR:     r_dir_cfg     <= i_cfg_data[0];
                default:     r_dir_cfg     <= r_dir_cfg;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_phase    <= PH_IDLE;
            r_bib      <= 5'd0;
            r_aad_left <= 7'd0;
            r_pay_left <= 7'd0;
            r_ctr      <= 16'd0;
            r_m        <= 5'd0;
            r_dir      <= 1'b0;
            r_has_pay  <= 1'b0;
            r_mac      <= '0;
            r_ks       <= '0;
            r_pend     <= '0;
            r_rtag     <= '0;
            r_nonce    <= '0;
            r_ov       <= 1'b0;
        end else begin
            if (emit) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        case (i_opcode)
                            OP_START: begin
                                r_nonce    <= {i_nonce_head, i_nonce_tail};
                                r_aad_left <= (m_ok && len_ok) ? i_aad_length : 7'd0;
                                r_pay_left <= (m_ok && len_ok) ? i_payload_length : 7'd0;
                                r_has_pay  <= (i_payload_length != 7'd0);
                                r_m        <= r_tag_len_cfg;
                                r_dir      <= r_dir_cfg;
                                r_pend     <= '0;
                                r_bib      <= 5'd0;
                                r_phase    <= PH_IDLE;
                                if (m_ok && len_ok) begin
                                    r_state <= S_B0;
                                end else begin
                                    r_vstat    <= ST_BAD_LEN;
                                    r_state    <= S_VERD;
                                end
                            end
                            OP_AAD: begin
                                if (r_phase == PH_AAD) begin
                                    r_pend[8*(4'd15 - bidx) +: 8] <= i_data_in;
                                    r_bib      <= r_bib + 5'd1;
                                    r_aad_left <= r_aad_left - 7'd1;
                                    r_state    <= S_POST;
                                end
                            end
                            OP_PAY: begin
                                if (r_phase == PH_PAY) begin
                                    r_din   <= i_data_in;
                                    r_state <= (r_bib == 5'd0) ? S_CTR : S_EMIT;
                                end
                            end
                            default: begin
                                if ((r_phase == PH_TAG) && (r_bib < r_m)) begin
                                    r_rtag[8*(4'd15 - bidx) +: 8] <= i_data_in;
                                    r_bib <= r_bib + 5'd1;
                                    if (r_bib + 5'd1 == r_m) begin
                                        r_state <= S_CMP;
                                    end
                                end
                            end
                        endcase
                    end
                end
                S_B0: begin
                    if (aes_rsp.done) begin
                        r_mac <= aes_rsp.result;
                        r_ctr <= 16'd1;
                        if (r_aad_left != 7'd0) begin
                            r_pend[119:112] <= {1'b0, r_aad_left};
                            r_bib   <= 5'd2;
                            r_phase <= PH_AAD;
                            r_state <= S_IDLE;
                        end else begin
                            r_phase <= PH_PAY;
                            r_state <= S_POST;
                        end
                    end
                end
                S_POST: begin
                    if (need_abs) begin
                        r_state <= S_ABS;
                    end else if (!data_done) begin
                        r_state <= S_IDLE;
                    end else if ((r_phase == PH_AAD) && (r_pay_left != 7'd0)) begin
                        r_phase <= PH_PAY;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_S0;
                    end
                end
                S_ABS: begin
                    if (aes_rsp.done) begin
                        r_mac   <= aes_rsp.result;
                        r_pend  <= '0;
                        r_bib   <= 5'd0;
                        r_state <= S_POST;
                    end
                end
                S_CTR: begin
                    if (aes_rsp.done) begin
                        r_ks    <= aes_rsp.result;
                        r_ctr   <= r_ctr + 16'd1;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (slot_free) begin
                        r_kind <= KIND_PAY;
                        r_dout <= o_byte;
                        r_stat <= ST_OK;
                        // no tag in encrypt mode: the final payload byte ends the frame
                        r_last <= (r_pay_left == 7'd1) && !r_dir && (r_m == 5'd0);
                        r_pend[8*(4'd15 - bidx) +: 8] <= r_dir ? o_byte : r_din;
                        r_bib      <= r_bib + 5'd1;
                        r_pay_left <= r_pay_left - 7'd1;
                        r_state    <= S_POST;
                    end
                end
                S_S0: begin
                    if (aes_rsp.done) begin
                        r_ks  <= tag_masked;
                        r_bib <= 5'd0;
                        if (!r_dir) begin
                            if (r_m != 5'd0) begin
                                r_state <= S_TOUT;
                            end else if (r_has_pay) begin
                                r_phase <= PH_IDLE;
                                r_state <= S_IDLE;
                            end else begin
                                r_vstat <= ST_OK;
                                r_state <= S_VERD;
                            end
                        end else if (r_m != 5'd0) begin
                            r_phase <= PH_TAG;
                            r_rtag  <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_vstat <= ST_OK;
                            r_state <= S_VERD;
                        end
                    end
                end
                S_TOUT: begin
                    if (slot_free) begin
                        r_kind <= KIND_TAG;
                        r_dout <= ks_byte;
                        r_stat <= ST_OK;
                        r_last <= (r_bib + 5'd1 == r_m);
                        r_bib  <= (r_bib + 5'd1 == r_m) ? 5'd0 : r_bib + 5'd1;
                        if (r_bib + 5'd1 == r_m) begin
                            r_phase <= PH_IDLE;
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_CMP: begin
                    r_vstat <= (r_rtag == r_ks) ? ST_OK : ST_MISMATCH;
                    r_phase <= PH_IDLE;
                    r_bib   <= 5'd0;
                    r_state <= S_VERD;
                end
                S_VERD: begin
                    if (slot_free) begin
                        r_kind  <= KIND_VERD;
                        r_dout  <= 8'h00;
                        r_stat  <= r_vstat;
                        r_last  <= 1'b1;
                        r_phase <= PH_IDLE;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_ov;
    assign o_kind      = r_kind;
    assign o_data_out  = r_dout;
    assign o_status    = r_stat;
    assign o_last      = r_last;

    a_bib_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bib <= 5'd16)
        else $error("block byte index past 16");
    a_aad_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_IDLE) && (r_phase == PH_AAD)) |-> (r_aad_left != 7'd0))
        else $error("aad phase idle with no bytes left");
    a_tag_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_TAG) |-> (r_dir && (r_m != 5'd0)))
        else $error("tag phase outside decrypt with tag");
    a_aes_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        aes_rsp.done |-> (r_state == S_B0 || r_state == S_ABS || r_state == S_CTR
                          || r_state == S_S0))
        else $error("aes result arrived with no waiting state");

endmodule
`default_nettype wire

// ===== tb/sv/tb_ccm_star_aes_frame_engine.sv =====
// Testbench for the CCM* frame engine: drives frames of words, predicts the
// result words with a behavioral AES-128/CCM* model and checks them in order.
// Depends on ccms_pkg and ccm_star_aes_frame_engine.
`timescale 1ns / 1ps
module tb_ccm_star_aes_frame_engine;
    import ccms_pkg::*;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [39:0] nonce_head;
        logic [63:0] nonce_tail;
        logic [6:0]  aad_length;
        logic [6:0]  payload_length;
        logic [7:0]  data_in;
    } t_word;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_out;
        logic [1:0] status;
        logic       last;
    } t_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic [1:0] i_opcode = '0;
    logic [39:0] i_nonce_head = '0;
    logic [63:0] i_nonce_tail = '0;
    logic [6:0] i_aad_length = '0;
    logic [6:0] i_payload_length = '0;
    logic [7:0] i_data_in = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic [1:0] o_kind;
    logic [7:0] o_data_out;
    logic [1:0] o_status;
    logic o_last;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [1:0] i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;

    ccm_star_aes_frame_engine i_dut (.*);

    always #5 i_clk = ~i_clk;

    // Predictor state
    logic [63:0] key_hi, key_lo;
    logic [4:0] tag_len_reg;
    logic dir_reg;
    logic [7:0] mac_st [16];
    logic [7:0] ks_st [16];
    logic [7:0] pend_st [16];
    logic [7:0] rtag_st [16];
    logic [7:0] nonce_st [13];
    logic [15:0] ctr_st;
    int aad_rem, pay_rem, blk_pos, tag_m;
    logic [1:0] phase;
    logic dir_lat;

    t_word pending_words[$];
    t_result expected_results[$];
    int errors = 0;
    bit drv_pause = 0;
    bit rx_hold = 0;

    task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        errors++;
    endtask

    function automatic void aes_block(ref logic [7:0] s[16]);
        logic [7:0] rk[16], t[16];
        logic [7:0] rc, a0, a1, a2, a3, al;
        rc = 8'h01;
        for (int i = 0; i < 8; i++) begin
            rk[i] = key_hi[63 - 8 * i -: 8];
            rk[8 + i] = key_lo[63 - 8 * i -: 8];
        end
        for (int i = 0; i < 16; i++) s[i] ^= rk[i];
        for (int r = 1; r <= 10; r++) begin
            for (int i = 0; i < 16; i++) t[i] = SBOX[s[i]];
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++) s[i + 4 * c] = t[i + 4 * ((c + i) & 3)];
            if (r != 10) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
                    al = a0 ^ a1 ^ a2 ^ a3;
                    s[4*c]   = a0 ^ al ^ {a0[6:0] ^ a1[6:0], 1'b0} ^ ((a0[7]^a1[7]) ? 8'h1b : 8'h0);
                    s[4*c+1] = a1 ^ al ^ {a1[6:0] ^ a2[6:0], 1'b0} ^ ((a1[7]^a2[7]) ? 8'h1b : 8'h0);
                    s[4*c+2] = a2 ^ al ^ {a2[6:0] ^ a3[6:0], 1'b0} ^ ((a2[7]^a3[7]) ? 8'h1b : 8'h0);
                    s[4*c+3] = a3 ^ al ^ {a3[6:0] ^ a0[6:0], 1'b0} ^ ((a3[7]^a0[7]) ? 8'h1b : 8'h0);
                end
            end
            rk[0] ^= SBOX[rk[13]] ^ rc;
            rk[1] ^= SBOX[rk[14]];
            rk[2] ^= SBOX[rk[15]];
            rk[3] ^= SBOX[rk[12]];
            for (int i = 4; i < 16; i++) rk[i] ^= rk[i - 4];
            rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
            for (int i = 0; i < 16; i++) s[i] ^= rk[i];
        end
    endfunction

    function automatic void ctr_keystream(input logic [15:0] cnt, ref logic [7:0] b[16]);
        b[0] = FLAG_L;
        for (int i = 0; i < 13; i++) b[1 + i] = nonce_st[i];
        b[14] = cnt[15:8];
        b[15] = cnt[7:0];
        aes_block(b);
    endfunction

    function automatic void mac_absorb();
        for (int i = 0; i < 16; i++) begin
            mac_st[i] ^= pend_st[i];
            pend_st[i] = 8'h00;
        end
        aes_block(mac_st);
        blk_pos = 0;
    endfunction

    function automatic void push_result(input logic [1:0] k, input logic [7:0] d,
                                        input logic [1:0] st, input logic l);
        t_result r;
        r.kind = k; r.data_out = d; r.status = st; r.last = l;
        expected_results.push_back(r);
    endfunction

    function automatic void close_frame(input bit had_payload, input int n_new);
        logic [7:0] s0[16];
        if (blk_pos != 0) mac_absorb();
        ctr_keystream(16'd0, s0);
        for (int i = 0; i < 16; i++) ks_st[i] = (i < tag_m) ? (mac_st[i] ^ s0[i]) : 8'h00;
        if (!dir_lat) begin
            phase = PH_IDLE;
            if (tag_m > 0) begin
                for (int i = 0; i < tag_m; i++) push_result(KIND_TAG, ks_st[i], ST_OK, i + 1 == tag_m);
            end else if (had_payload && n_new > 0) begin
                expected_results[$].last = 1'b1;
            end else begin
                push_result(KIND_VERD, 8'h00, ST_OK, 1'b1);
            end
        end else if (tag_m > 0) begin
            phase = PH_TAG;
            blk_pos = 0;
            for (int i = 0; i < 16; i++) rtag_st[i] = 8'h00;
        end else begin
            phase = PH_IDLE;
            push_result(KIND_VERD, 8'h00, ST_OK, 1'b1);
        end
    endfunction

    function automatic void predict_frame_word(input t_word w);
        logic [7:0] o;
        logic mism;
        case (w.opcode)
            OP_START: begin
                for (int i = 0; i < 5; i++) nonce_st[i] = w.nonce_head[39 - 8 * i -: 8];
                for (int i = 0; i < 8; i++) nonce_st[5 + i] = w.nonce_tail[63 - 8 * i -: 8];
                aad_rem = w.aad_length;
                pay_rem = w.payload_length;
                tag_m = tag_len_reg;
                dir_lat = dir_reg;
                for (int i = 0; i < 16; i++) pend_st[i] = 8'h00;
                blk_pos = 0;
                if (!(tag_m == 0 || tag_m == 4 || tag_m == 8 || tag_m == 16)
                        || aad_rem + pay_rem > 127) begin
                    phase = PH_IDLE;
                    aad_rem = 0; pay_rem = 0;
                    push_result(KIND_VERD, 8'h00, ST_BAD_LEN, 1'b1);
                end else begin
                    mac_st[0] = FLAG_L | (tag_m != 0 ? 8'((tag_m - 2) / 2) << 3 : 8'h00)
                                | (aad_rem != 0 ? FLAG_ADATA : 8'h00);
                    for (int i = 0; i < 13; i++) mac_st[1 + i] = nonce_st[i];
                    mac_st[14] = 8'h00;
                    mac_st[15] = 8'(pay_rem);
                    aes_block(mac_st);
                    ctr_st = 16'd1;
                    if (aad_rem > 0) begin
                        pend_st[1] = 8'(aad_rem);
                        blk_pos = 2;
                        phase = PH_AAD;
                    end else if (pay_rem > 0) begin
                        phase = PH_PAY;
                    end else begin
                        close_frame(0, 0);
                    end
                end
            end
            OP_AAD: begin
                if (phase == PH_AAD && aad_rem != 0) begin
                    pend_st[blk_pos] = w.data_in;
                    blk_pos++;
                    if (blk_pos >= 16) mac_absorb();
                    aad_rem--;
                    if (aad_rem == 0) begin
                        if (blk_pos != 0) mac_absorb();
                        if (pay_rem > 0) phase = PH_PAY;
                        else close_frame(0, 0);
                    end
                end
            end
            OP_PAY: begin
                if (phase == PH_PAY && pay_rem != 0) begin
                    if (blk_pos == 0) begin
                        ctr_keystream(ctr_st, ks_st);
                        ctr_st++;
                    end
                    o = w.data_in ^ ks_st[blk_pos];
                    pend_st[blk_pos] = dir_lat ? o : w.data_in;
                    push_result(KIND_PAY, o, ST_OK, 1'b0);
                    blk_pos++;
                    if (blk_pos >= 16) mac_absorb();
                    pay_rem--;
                    if (pay_rem == 0) close_frame(1, 1);
                end
            end
            default: begin
                if (phase == PH_TAG && blk_pos < tag_m && tag_m <= 16) begin
                    rtag_st[blk_pos] = w.data_in;
                    blk_pos++;
                    if (blk_pos >= tag_m) begin
                        phase = PH_IDLE;
                        blk_pos = 0;
                        mism = 0;
                        for (int i = 0; i < tag_m; i++) if (rtag_st[i] != ks_st[i]) mism = 1;
                        push_result(KIND_VERD, 8'h00, mism ? ST_MISMATCH : ST_OK, 1'b1);
                    end
                end
            end
        endcase
    endfunction

    // Driver: bursts with random gaps
    int burst_left = 0;
    int gap_left = 0;
    bit in_taken = 0;

    // a word accepted at a rising edge is predicted at that edge, before its results
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            predict_frame_word(pending_words.pop_front());
            in_taken = 1;
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || in_taken) begin
                in_taken = 0;
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_words.size() > 0 && !drv_pause) begin
                    {i_opcode, i_nonce_head, i_nonce_tail, i_aad_length,
                     i_payload_length, i_data_in} <= pending_words[0];
                    i_in_valid <= 1'b1;
                    if (burst_left > 0) burst_left--;
                    else begin
                        burst_left = $urandom_range(0, 30);
                        gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver ready pattern: free-running stretches, random stalls, long hold-off
    int stall_phase = 0;
    always @(negedge i_clk) begin
        stall_phase++;
        if (rx_hold) i_out_ready <= 1'b0;
        else if ((stall_phase / 64) % 3 == 0) i_out_ready <= 1'b1;
        else i_out_ready <= ($urandom_range(0, 3) != 0);
    end

    // Monitor
    t_result exp_r;
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                report("unexpected word", {6'b0, o_kind}, 8'h00);
            end else begin
                exp_r = expected_results.pop_front();
                if (o_kind !== exp_r.kind) report("kind", {6'b0, o_kind}, {6'b0, exp_r.kind});
                if (o_data_out !== exp_r.data_out) report("data_out", o_data_out, exp_r.data_out);
                if (o_status !== exp_r.status)
                    report("status", {6'b0, o_status}, {6'b0, exp_r.status});
                if (o_last !== exp_r.last) report("last", {7'b0, o_last}, {7'b0, exp_r.last});
            end
        end
    end

    function automatic t_word mk(input logic [1:0] op, input logic [7:0] d);
        t_word w;
        w = '0;
        w.opcode = op;
        w.data_in = d;
        w.nonce_head = 40'({$urandom, $urandom});
        w.nonce_tail = {$urandom, $urandom};
        w.aad_length = 7'($urandom);
        w.payload_length = 7'($urandom);
        return w;
    endfunction

    function automatic void queue_frame(input int na, input int np, input int ntag,
                                        input bit noisy);
        t_word w;
        w = mk(OP_START, 8'($urandom));
        w.aad_length = 7'(na);
        w.payload_length = 7'(np);
        pending_words.push_back(w);
        for (int i = 0; i < na; i++) pending_words.push_back(mk(OP_AAD, 8'($urandom)));
        for (int i = 0; i < np; i++) begin
            if (noisy && $urandom_range(0, 9) == 0)
                pending_words.push_back(mk(2'($urandom_range(1, 3)), 8'($urandom)));
            pending_words.push_back(mk(OP_PAY, 8'($urandom)));
        end
        for (int i = 0; i < ntag; i++) pending_words.push_back(mk(OP_TAG, 8'($urandom)));
    endfunction

    task automatic settle();
        while (pending_words.size() > 0 || i_in_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_KEY_UP:  key_hi = val;
            CFG_KEY_LO:  key_lo = val;
            CFG_TAG_LEN: tag_len_reg = val[4:0];
            default:     dir_reg = val[0];
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int tl, m;
        t_word w;
        key_hi = '0; key_lo = '0; tag_len_reg = 5'd8; dir_reg = 1'b0;
        for (int i = 0; i < 16; i++) begin
            mac_st[i] = 0; ks_st[i] = 0; pend_st[i] = 0; rtag_st[i] = 0;
        end
        for (int i = 0; i < 13; i++) nonce_st[i] = 0;
        ctr_st = 0; aad_rem = 0; pay_rem = 0; blk_pos = 0; tag_m = 0;
        phase = PH_IDLE; dir_lat = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset key, tag 8, encrypt
        queue_frame(3, 5, 0, 0);
        queue_frame(0, 0, 0, 0);
        w = mk(OP_START, 8'h00);
        w.nonce_head = '1; w.nonce_tail = '1; w.aad_length = 7'd127; w.payload_length = 7'd1;
        pending_words.push_back(w);                     // frame too long
        pending_words.push_back(mk(OP_TAG, 8'hff));     // out of phase
        queue_frame(1, 0, 0, 0);
        pending_words.push_back(mk(OP_PAY, 8'h00));     // ignored
        settle();
        write_reg(CFG_KEY_UP, 64'hffff_ffff_ffff_ffff);
        write_reg(CFG_KEY_LO, 64'h0);
        write_reg(CFG_TAG_LEN, 64'd5);
        queue_frame(0, 2, 0, 0);                         // bad tag length
        settle();
        write_reg(CFG_TAG_LEN, 64'd0);
        queue_frame(0, 3, 0, 0);                         // tag 0, last on payload
        queue_frame(0, 0, 0, 0);                         // empty frame verdict
        settle();
        write_reg(CFG_DIR, 64'd1);
        queue_frame(2, 2, 0, 0);                         // decrypt, tag 0
        settle();
        write_reg(CFG_TAG_LEN, 64'd16);
        queue_frame(0, 1, 16, 0);
        queue_frame(2, 0, 2, 0);                         // restart mid-tag
        queue_frame(0, 0, 16, 0);
        settle();

        // Random phases through several settings
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(CFG_KEY_UP, {$urandom, $urandom});
            write_reg(CFG_KEY_LO, {$urandom, $urandom});
            tl = $urandom_range(0, 9);
            m = (tl < 2) ? 0 : (tl < 4) ? 4 : (tl < 6) ? 8 : (tl < 8) ? 16 : $urandom_range(0, 31);
            write_reg(CFG_TAG_LEN, 64'(m));
            write_reg(CFG_DIR, 64'(ph & 1));
            for (int f = 0; f < 2; f++) begin
                if ($urandom_range(0, 9) == 0) begin
                    pending_words.push_back(mk(2'($urandom_range(0, 3)), 8'($urandom)));
                end else begin
                    queue_frame($urandom_range(0, 4) == 0 ? $urandom_range(0, 24)
                                                          : $urandom_range(0, 6),
                                $urandom_range(0, 4) == 0 ? $urandom_range(0, 24)
                                                          : $urandom_range(0, 12),
                                (ph & 1) ? (($urandom_range(0, 3) == 0) ? m / 2 : m) : 0,
                                1);
                end
                if (ph == 3 && f == 0) begin
                    // long receiver hold-off while words keep coming
                    rx_hold = 1;
                    repeat (400) @(posedge i_clk);
                    rx_hold = 0;
                end
                if (ph == 5 && f == 1) begin
                    // sender waits for every expected word
                    drv_pause = 1;
                    while (i_in_valid || expected_results.size() > 0) @(posedge i_clk);
                    drv_pause = 0;
                end
            end
            settle();
        end

        if (errors == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

    initial begin
        #20ms;
        $display("FAIL");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/core/ccms_pkg.sv
rtl/core/ccms_aes.sv
rtl/core/ccm_star_aes_frame_engine.sv
tb/sv/tb_ccm_star_aes_frame_engine.sv
